FILE: rtl/core/pta_pkg.sv
// ----------------------------------------------------------------------------
// Page table mapper package
// Field widths, register indexes, outcome codes and the cell control bundle
// shared by the mapper, its cells and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pta_pkg;

   // Request and response field widths
   localparam int ADDR_W  = 20;   // virtual address and virtual page
   localparam int PAGE_W  = 17;   // memory size and page size registers
   localparam int PHYS_W  = 16;   // physical address
   localparam int FRAME_W = 6;    // reported frame number
   localparam int OUT_W   = 2;    // outcome code

   // Table positions and frame numbers, wide enough for the largest table
   localparam int POS_W = 11;

   // Divider widths
   localparam int DIV_W = ADDR_W;
   localparam int DSR_W = PAGE_W;

   // Parameter defaults
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_VADDR_BITS  = 20;

   // Register values after reset
   localparam logic [PAGE_W-1:0] RST_MEMORY_SIZE = PAGE_W'(256);
   localparam logic [PAGE_W-1:0] RST_PAGE_BYTES  = PAGE_W'(16);
   localparam int                RST_CAPACITY    = 16;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY      = 2'd2;

   // Replacement policies
   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   // Outcome codes
   localparam logic [OUT_W-1:0] OUT_HIT   = 2'd0;
   localparam logic [OUT_W-1:0] OUT_EVICT = 2'd1;
   localparam logic [OUT_W-1:0] OUT_FILL  = 2'd2;

   // Control bundle broadcast to every cell of the table
   typedef struct packed {
      logic              compare;     // register match against vpage
      logic              shift_en;    // cells at or past shift_from take neighbor
      logic [POS_W-1:0]  shift_from;
      logic              load_en;     // cell at load_pos takes vpage/frame
      logic [POS_W-1:0]  load_pos;
      logic [POS_W-1:0]  fill;        // number of valid entries
      logic [ADDR_W-1:0] vpage;
      logic [POS_W-1:0]  frame;
   } pta_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/pta_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when quotient and remainder are valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pta_pkg::DIV_W-1:0]  dividend,
   input  wire logic [pta_pkg::DSR_W-1:0]  divisor,
   output logic                            done,
   output logic [pta_pkg::DIV_W-1:0]       quotient,
   output logic [pta_pkg::DSR_W-1:0]       remainder
);
   import pta_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] dvd_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DSR_W-1:0] rem_ff;
   logic [DSR_W-1:0] dsr_ff;

   logic [DSR_W:0]   trial;
   logic [DSR_W:0]   diff;
   logic             ge;

   // Trial subtract of the next partial remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[DIV_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   // Iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: shift dividend out, quotient bits in
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         quo_ff <= '0;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pta_cell.sv
// ----------------------------------------------------------------------------
// Page table cell
// Holds one table slot (virtual page and frame). Compares against the
// broadcast page, takes its back neighbor's slot when the table shifts
// toward the front, or loads the broadcast page and frame.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_cell #(
   parameter int CELL_IDX = 0,
   parameter int FRM_W    = 6
) (
   input  wire logic                        clock,
   input  wire pta_pkg::pta_ctl_type        ctl,
   input  wire logic [pta_pkg::ADDR_W-1:0]  next_vpage,
   input  wire logic [FRM_W-1:0]            next_frame,
   output logic [pta_pkg::ADDR_W-1:0]       vpage,
   output logic [FRM_W-1:0]                 frame,
   output logic                             match
);
   import pta_pkg::*;

   localparam logic [POS_W-1:0] POS      = POS_W'(CELL_IDX);
   localparam logic [POS_W-1:0] POS_NEXT = POS_W'(CELL_IDX + 1);

   logic [ADDR_W-1:0] vpage_ff;
   logic [FRM_W-1:0]  frame_ff;
   logic              match_ff;

   // Match flag, only for slots inside the valid part
   always_ff @(posedge clock) begin
      if (ctl.compare) begin
         match_ff <= (POS < ctl.fill) && (vpage_ff == ctl.vpage);
      end
   end

   // Slot contents: load or take the neighbor behind
   always_ff @(posedge clock) begin
      if (ctl.load_en && (ctl.load_pos == POS)) begin
         vpage_ff <= ctl.vpage;
         frame_ff <= ctl.frame[FRM_W-1:0];
      end else if (ctl.shift_en && (POS >= ctl.shift_from) && (POS_NEXT < ctl.fill)) begin
         vpage_ff <= next_vpage;
         frame_ff <= next_frame;
      end
   end

   assign vpage = vpage_ff;
   assign frame = frame_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

FILE: rtl/core/page_table_lru_fifo_mapper.sv
// ----------------------------------------------------------------------------
// Page table mapper with LRU / FIFO replacement
// Translates virtual addresses through an ordered table kept in a row of
// cells; misses fill free slots or evict the front entry.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | vaddr
//   rsp     | out       | rsp_valid/rsp_stall | outcome, virtual_page, frame,
//           |           |                     | physical_address
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One request at a time: the divider loads on the accept edge and runs to its done
// pulse, then the compare, reduce and decide states follow in order and the
// response register is loaded from ST_OUT. A new request is taken only after
// the previous response has been registered.
// A write to a mapped register clears the table and recomputes capacity with
// the same divider, with csr_ready low and req_stall high until it is done.
// Reset is synchronous; the table is empty and capacity is 16 after reset.
// A stalled response holds; a new request is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_lru_fifo_mapper #(
   parameter int MAX_ENTRIES = pta_pkg::DEF_MAX_ENTRIES,
   parameter int VADDR_BITS  = pta_pkg::DEF_VADDR_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pta_pkg::ADDR_W-1:0]    req_vaddr,
   // Response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pta_pkg::OUT_W-1:0]          rsp_outcome,
   output logic [pta_pkg::ADDR_W-1:0]         rsp_virtual_page,
   output logic [pta_pkg::FRAME_W-1:0]        rsp_frame,
   output logic [pta_pkg::PHYS_W-1:0]         rsp_physical_address,
   // Register write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pta_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pta_pkg::PAGE_W-1:0]    csr_wdata
);
   import pta_pkg::*;

   localparam int FRM_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int AW      = (VADDR_BITS < ADDR_W) ? VADDR_BITS : ADDR_W;
   localparam int CAP_RST = (RST_CAPACITY < MAX_ENTRIES) ? RST_CAPACITY : MAX_ENTRIES;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAP_START,
      ST_CAP_WAIT,
      ST_ADDR_WAIT,
      ST_COMPARE,
      ST_REDUCE,
      ST_DECIDE,
      ST_OUT
   } state_type;

   state_type          state_ff;
   logic [PAGE_W-1:0]  memsz_ff;
   logic [PAGE_W-1:0]  pgsz_ff;
   logic               policy_ff;
   logic [CNT_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [ADDR_W-1:0]  vp_ff;
   logic [DSR_W-1:0]   off_ff;
   logic               hit_ff;
   logic [POS_W-1:0]   hit_idx_ff;
   logic [FRM_W-1:0]   hit_frame_ff;
   logic [OUT_W-1:0]   outcome_ff;
   logic [POS_W-1:0]   fr_ff;
   logic [PHYS_W-1:0]  prod_ff;
   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rsp_outcome_ff;
   logic [ADDR_W-1:0]  rsp_vpage_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [PHYS_W-1:0]  rsp_phys_ff;

   logic               req_take;
   logic               csr_take;
   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DSR_W-1:0]   eff_page;
   logic               div_done;
   logic [DIV_W-1:0]   div_quo;
   logic [DSR_W-1:0]   div_rem;
   logic [CNT_W-1:0]   cap_in;
   logic [CNT_W-1:0]   fill_in;
   logic [OUT_W-1:0]   outcome_in;
   logic [POS_W-1:0]   fr_in;
   logic               out_free;

   pta_ctl_type        ctl;

   logic [ADDR_W-1:0]  cell_vpage [MAX_ENTRIES];
   logic [FRM_W-1:0]   cell_frame [MAX_ENTRIES];
   logic               cell_match [MAX_ENTRIES];

   logic               red_hit;
   logic [POS_W-1:0]   red_idx;
   logic [FRM_W-1:0]   red_frame;

   // Handshakes: register writes take priority over requests
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_take  = csr_valid && csr_ready;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Divider operands: address on a request, memory size on a recompute
   assign eff_page     = (pgsz_ff == '0) ? DSR_W'(1) : pgsz_ff;
   assign div_start    = req_take || (state_ff == ST_CAP_START);
   assign div_dividend = (state_ff == ST_CAP_START) ? DIV_W'(memsz_ff)
                                                    : DIV_W'(req_vaddr[AW-1:0]);

   pta_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (eff_page),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Capacity saturated to 1..MAX_ENTRIES
   always_comb begin
      if (div_quo == '0) begin
         cap_in = CNT_W'(1);
      end else if (div_quo > DIV_W'(MAX_ENTRIES)) begin
         cap_in = CNT_W'(MAX_ENTRIES);
      end else begin
         cap_in = div_quo[CNT_W-1:0];
      end
   end

   // Replacement decision and cell control
   always_comb begin
      ctl            = '0;
      ctl.compare    = (state_ff == ST_COMPARE);
      ctl.fill       = POS_W'(fill_ff);
      ctl.vpage      = vp_ff;
      fill_in        = fill_ff;
      outcome_in     = OUT_HIT;
      fr_in          = POS_W'(hit_frame_ff);
      if (hit_ff) begin
         // hit: LRU moves the entry to the back, FIFO leaves the order
         ctl.shift_en   = (policy_ff == POLICY_LRU);
         ctl.shift_from = hit_idx_ff;
         ctl.load_en    = (policy_ff == POLICY_LRU);
         ctl.load_pos   = POS_W'(fill_ff) - 1'b1;
         ctl.frame      = POS_W'(hit_frame_ff);
      end else if (fill_ff < cap_ff) begin
         // miss with room: next free slot, frame is its own index
         outcome_in   = OUT_FILL;
         fr_in        = POS_W'(fill_ff);
         ctl.load_en  = 1'b1;
         ctl.load_pos = POS_W'(fill_ff);
         ctl.frame    = POS_W'(fill_ff);
         fill_in      = fill_ff + 1'b1;
      end else begin
         // miss with full table: evict front, reuse its frame at the back
         outcome_in     = OUT_EVICT;
         fr_in          = POS_W'(cell_frame[0]);
         ctl.shift_en   = 1'b1;
         ctl.shift_from = '0;
         ctl.load_en    = 1'b1;
         ctl.load_pos   = POS_W'(fill_ff) - 1'b1;
         ctl.frame      = POS_W'(cell_frame[0]);
      end
      if (state_ff != ST_DECIDE) begin
         ctl.shift_en = 1'b0;
         ctl.load_en  = 1'b0;
      end
   end

   // Row of table cells, each but the last fed by the cell behind it
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      logic [ADDR_W-1:0] nb_vpage;
      logic [FRM_W-1:0]  nb_frame;
      if (k < MAX_ENTRIES - 1) begin : g_nb
         assign nb_vpage = cell_vpage[k+1];
         assign nb_frame = cell_frame[k+1];
      end else begin : g_last
         assign nb_vpage = vp_ff;
         assign nb_frame = hit_frame_ff;
      end
      pta_cell #(
         .CELL_IDX (k),
         .FRM_W    (FRM_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .next_vpage (nb_vpage),
         .next_frame (nb_frame),
         .vpage      (cell_vpage[k]),
         .frame      (cell_frame[k]),
         .match      (cell_match[k])
      );
   end

   // Match reduction: at most one valid cell matches
   always_comb begin
      red_hit   = 1'b0;
      red_idx   = '0;
      red_frame = '0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         if (cell_match[k]) begin
            red_hit   = 1'b1;
            red_idx   = red_idx | POS_W'(k);
            red_frame = red_frame | cell_frame[k];
         end
      end
   end

   // Sequencer, registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         memsz_ff     <= RST_MEMORY_SIZE;
         pgsz_ff      <= RST_PAGE_BYTES;
         policy_ff    <= POLICY_LRU;
         cap_ff       <= CNT_W'(CAP_RST);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response valid: set when a response is registered, cleared when taken
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (csr_take) begin
                  case (csr_index)
                     CSR_MEMORY_SIZE: begin
                        memsz_ff <= csr_wdata;
                        fill_ff  <= '0;
                        state_ff <= ST_CAP_START;
                     end
                     CSR_PAGE_BYTES: begin
                        pgsz_ff  <= csr_wdata;
                        fill_ff  <= '0;
                        state_ff <= ST_CAP_START;
                     end
                     CSR_POLICY: begin
                        policy_ff <= csr_wdata[0];
                        fill_ff   <= '0;
                        state_ff  <= ST_CAP_START;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end else if (req_take) begin
                  state_ff <= ST_ADDR_WAIT;
               end
            end
            ST_CAP_START: begin
               state_ff <= ST_CAP_WAIT;
            end
            ST_CAP_WAIT: begin
               if (div_done) begin
                  cap_ff   <= cap_in;
                  state_ff <= ST_IDLE;
               end
            end
            ST_ADDR_WAIT: begin
               if (div_done) begin
                  state_ff <= ST_COMPARE;
               end
            end
            ST_COMPARE: begin
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               fill_ff  <= fill_in;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR_WAIT && div_done) begin
         vp_ff  <= div_quo;
         off_ff <= div_rem;
      end
      if (state_ff == ST_REDUCE) begin
         hit_ff       <= red_hit;
         hit_idx_ff   <= red_idx;
         hit_frame_ff <= red_frame;
      end
      if (state_ff == ST_DECIDE) begin
         outcome_ff <= outcome_in;
         fr_ff      <= fr_in;
         prod_ff    <= PHYS_W'(PHYS_W'(fr_in) * eff_page[PHYS_W-1:0]);
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_outcome_ff <= outcome_ff;
         rsp_vpage_ff   <= vp_ff;
         rsp_frame_ff   <= fr_ff[FRAME_W-1:0];
         rsp_phys_ff    <= prod_ff + off_ff[PHYS_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_virtual_page     = rsp_vpage_ff;
   assign rsp_frame            = rsp_frame_ff;
   assign rsp_physical_address = rsp_phys_ff;

endmodule

`default_nettype wire

FILE: tb/sv/page_table_lru_fifo_mapper_test.sv
// ----------------------------------------------------------------------------
// Page table mapper regression
// Drives virtual addresses into the mapper under many table sizes, page sizes
// and both replacement policies. A behavioral copy of the ordered table
// predicts every response; responses are checked field by field in order.
// Both sides insert random gaps, and one long response hold-off backs the
// mapper up into its request side.
// ----------------------------------------------------------------------------
module page_table_lru_fifo_mapper_test;
   import pta_pkg::*;

   localparam int TABLE_DEPTH     = DEF_MAX_ENTRIES;
   localparam int unsigned VA_MASK = (1 << DEF_VADDR_BITS) - 1;
   localparam int IDLE_LIMIT      = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 400;
   localparam int FIXED_PHASES    = 6;
   localparam int TOTAL_PHASES    = 16;
   localparam int PHASE_REQUESTS  = 114;
   localparam int DRAIN_CYCLES    = 64;
   localparam int REPORT_LIMIT    = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [OUT_W-1:0]   outcome;
      logic [ADDR_W-1:0]  vpage;
      logic [FRAME_W-1:0] frame;
      logic [PHYS_W-1:0]  phys;
   } xlat_type;

   typedef enum logic {ROW_XLAT, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [PAGE_W-1:0]    wdata;
      logic [ADDR_W-1:0]    vaddr;
      logic                 typed;
      xlat_type             want;
   } stim_row_type;

   localparam xlat_type NO_XLAT = '0;

   // Settings for the first random phases: saturated, single entry, odd sizes
   localparam logic [PAGE_W-1:0] FIXED_MEM [FIXED_PHASES] =
      '{17'h10000, 17'h1FFFF, 17'd1, 17'h10000, 17'd4096, 17'd5};
   localparam logic [PAGE_W-1:0] FIXED_PAGE [FIXED_PHASES] =
      '{17'd1, 17'h1FFFF, 17'd1, 17'd1024, 17'd256, 17'd0};
   localparam logic FIXED_POLICY [FIXED_PHASES] =
      '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO};

   // Directed requests; reset state is 16 entries of 16-byte pages, LRU
   localparam int DIRECTED_ROWS = 28;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00000, 1'b1,
        '{OUT_FILL, 20'h00000, 6'd0, 16'h0000}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'hFFFFF, 1'b1,
        '{OUT_FILL, 20'h0FFFF, 6'd1, 16'h001F}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00005, 1'b1,
        '{OUT_HIT, 20'h00000, 6'd0, 16'h0005}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h0001F, 1'b1,
        '{OUT_FILL, 20'h00001, 6'd2, 16'h002F}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00020, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00031, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00042, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00053, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00064, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00075, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00086, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00097, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h000A8, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h000B9, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h000CA, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h000DB, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h000EC, 1'b0, NO_XLAT},
      // table full: front entry (page FFFF, frame 1) goes
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h01000, 1'b1,
        '{OUT_EVICT, 20'h00100, 6'd1, 16'h0010}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'hFFFF0, 1'b0, NO_XLAT},
      // zero page size acts as one byte; zero memory still gives one entry
      '{ROW_WRITE, CSR_PAGE_BYTES, 17'd0, 20'h00000, 1'b0, NO_XLAT},
      '{ROW_WRITE, CSR_MEMORY_SIZE, 17'd0, 20'h00000, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'hFFFFF, 1'b1,
        '{OUT_FILL, 20'hFFFFF, 6'd0, 16'h0000}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00007, 1'b1,
        '{OUT_EVICT, 20'h00007, 6'd0, 16'h0000}},
      '{ROW_WRITE, CSR_POLICY, 17'd1, 20'h00000, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00007, 1'b1,
        '{OUT_FILL, 20'h00007, 6'd0, 16'h0000}},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00007, 1'b1,
        '{OUT_HIT, 20'h00007, 6'd0, 16'h0000}},
      // unmapped register index: ignored, table keeps its entry
      '{ROW_WRITE, CSR_UNMAPPED, 17'h1FFFF, 20'h00000, 1'b0, NO_XLAT},
      '{ROW_XLAT, CSR_MEMORY_SIZE, 17'd0, 20'h00007, 1'b1,
        '{OUT_HIT, 20'h00007, 6'd0, 16'h0000}}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ADDR_W-1:0]    req_vaddr = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OUT_W-1:0]     rsp_outcome;
   logic [ADDR_W-1:0]    rsp_virtual_page;
   logic [FRAME_W-1:0]   rsp_frame;
   logic [PHYS_W-1:0]    rsp_physical_address;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PAGE_W-1:0]    csr_wdata = '0;

   page_table_lru_fifo_mapper dut (.*);

   initial forever #2 clock = ~clock;

   // Table copy, front entry at index 0
   logic [ADDR_W-1:0]  table_vpage [TABLE_DEPTH];
   logic [FRAME_W-1:0] table_frame [TABLE_DEPTH];
   int unsigned        table_fill = 0;
   int unsigned        table_capacity = RST_CAPACITY;
   logic [PAGE_W-1:0]  cfg_memory_size = RST_MEMORY_SIZE;
   logic [PAGE_W-1:0]  cfg_page_bytes = RST_PAGE_BYTES;
   logic               cfg_policy = POLICY_LRU;

   xlat_type pending_translations [$];
   int    requests_accepted = 0;
   int    translations_checked = 0;
   int    translation_errors = 0;
   int    register_writes = 0;
   int    hit_count = 0;
   int    evict_count = 0;
   int    fill_count = 0;
   bit    hold_off_done = 1'b0;

   function automatic int unsigned cur_page_bytes();
      return (cfg_page_bytes == 0) ? 1 : cfg_page_bytes;
   endfunction

   // Register write: every mapped index clears the table
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [PAGE_W-1:0] data);
      int unsigned cap;
      case (idx)
         CSR_MEMORY_SIZE: cfg_memory_size = data;
         CSR_PAGE_BYTES:  cfg_page_bytes = data;
         CSR_POLICY:      cfg_policy = data[0];
         default:         return;
      endcase
      cap = cfg_memory_size / cur_page_bytes();
      if (cap < 1) cap = 1;
      if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
      table_capacity = cap;
      table_fill = 0;
   endfunction

   // One translation: search front to back, then hit, fill or evict
   function automatic xlat_type translate_address(input logic [ADDR_W-1:0] vaddr);
      int unsigned pg, addr, off, pos, k, fr;
      logic [ADDR_W-1:0] vp;
      xlat_type res;
      pg = cur_page_bytes();
      addr = vaddr & VA_MASK;
      vp = ADDR_W'(addr / pg);
      off = addr % pg;
      pos = 0;
      while (pos < table_fill && table_vpage[pos] != vp) pos++;
      if (pos < table_fill) begin
         res.outcome = OUT_HIT;
         fr = table_frame[pos];
         if (cfg_policy == POLICY_LRU) begin
            for (k = pos; k + 1 < table_fill; k++) begin
               table_vpage[k] = table_vpage[k + 1];
               table_frame[k] = table_frame[k + 1];
            end
            table_vpage[table_fill - 1] = vp;
            table_frame[table_fill - 1] = FRAME_W'(fr);
         end
      end else if (table_fill < table_capacity) begin
         res.outcome = OUT_FILL;
         fr = table_fill;
         table_vpage[table_fill] = vp;
         table_frame[table_fill] = FRAME_W'(fr);
         table_fill++;
      end else begin
         res.outcome = OUT_EVICT;
         fr = table_frame[0];
         for (k = 0; k + 1 < table_fill; k++) begin
            table_vpage[k] = table_vpage[k + 1];
            table_frame[k] = table_frame[k + 1];
         end
         table_vpage[table_fill - 1] = vp;
         table_frame[table_fill - 1] = FRAME_W'(fr);
      end
      res.vpage = vp;
      res.frame = FRAME_W'(fr);
      res.phys = PHYS_W'(fr * pg + off);
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Address from a window of pages around the table size, some noise
   function automatic logic [ADDR_W-1:0] pick_address(input int unsigned base,
                                                      input int unsigned span);
      int unsigned pg;
      pg = cur_page_bytes();
      if ($urandom_range(0, 9) == 0) return ADDR_W'($urandom);
      return ADDR_W'((base + $urandom_range(0, span - 1)) * pg
                     + $urandom_range(0, pg - 1));
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [PAGE_W-1:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      apply_register(idx, data);
      register_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one request; typed rows override the predicted expectation
   task automatic offer_translation(input logic [ADDR_W-1:0] vaddr, input int gap,
                                    input logic typed, input xlat_type want);
      xlat_type predicted;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_vaddr = vaddr;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = translate_address(vaddr);
      pending_translations.push_back(typed ? want : predicted);
      requests_accepted++;
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      translation_errors++;
      if (translation_errors <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   task automatic check_response();
      xlat_type want;
      if (pending_translations.size() == 0) begin
         translation_errors++;
         if (translation_errors <= REPORT_LIMIT)
            $display("%0t: response with no request outstanding, expected none, actual page %0h",
                     $time, rsp_virtual_page);
      end else begin
         want = pending_translations.pop_front();
         translations_checked++;
         case (want.outcome)
            OUT_HIT:   hit_count++;
            OUT_EVICT: evict_count++;
            default:   fill_count++;
         endcase
         if (rsp_outcome !== want.outcome)
            report_field("outcome", want.outcome, rsp_outcome);
         if (rsp_virtual_page !== want.vpage)
            report_field("virtual_page", want.vpage, rsp_virtual_page);
         if (rsp_frame !== want.frame)
            report_field("frame", want.frame, rsp_frame);
         if (rsp_physical_address !== want.phys)
            report_field("physical_address", want.phys, rsp_physical_address);
      end
   endtask

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) check_response();
   end

   // Receiver stalls, with one long hold-off once traffic is under way
   task automatic drive_stall(input logic level, input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         rsp_stall = level;
      end
   endtask

   initial begin
      forever begin
         if (!hold_off_done && requests_accepted >= HOLD_OFF_AFTER) begin
            drive_stall(1'b1, HOLD_OFF_CYCLES);
            hold_off_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            drive_stall(1'b0, $urandom_range(20, 120));
         end else begin
            drive_stall(1'b1, pick_gap());
            drive_stall(1'b0, $urandom_range(1, 8));
         end
      end
   end

   // Watchdog: any handshake restarts the count
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
             || (csr_valid && csr_ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
               $time, IDLE_LIMIT, pending_translations.size());
      $display("page_table_lru_fifo_mapper regression: fail");
      $finish;
   end

   // Stimulus
   initial begin
      stim_row_type         row;
      logic [CSR_IDX_W-1:0] order [3];
      logic [CSR_IDX_W-1:0] tmp;
      logic [PAGE_W-1:0]    values [3];
      int unsigned          space, span, base;
      int                   phase, n, k, j;
      bit                   burst;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.kind == ROW_WRITE)
            write_register(row.index, row.wdata);
         else
            offer_translation(row.vaddr, pick_gap(), row.typed, row.want);
      end

      for (phase = 0; phase < TOTAL_PHASES; phase++) begin
         // pick a setting and write all three registers in random order
         if (phase < FIXED_PHASES) begin
            values[CSR_MEMORY_SIZE] = FIXED_MEM[phase];
            values[CSR_PAGE_BYTES] = FIXED_PAGE[phase];
            values[CSR_POLICY] = {16'd0, FIXED_POLICY[phase]};
         end else begin
            values[CSR_PAGE_BYTES] = ($urandom_range(0, 3) != 0) ?
               PAGE_W'($urandom_range(0, 4096)) : PAGE_W'($urandom_range(0, 17'h1FFFF));
            values[CSR_MEMORY_SIZE] = ($urandom_range(0, 1) != 0) ?
               PAGE_W'(values[CSR_PAGE_BYTES] * $urandom_range(0, 70)) :
               PAGE_W'($urandom_range(0, 17'h1FFFF));
            values[CSR_POLICY] = PAGE_W'($urandom_range(0, 17'h1FFFF));
         end
         order = '{CSR_MEMORY_SIZE, CSR_PAGE_BYTES, CSR_POLICY};
         for (k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
         end
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_UNMAPPED, PAGE_W'($urandom_range(0, 17'h1FFFF)));
         for (k = 0; k < 3; k++) write_register(order[k], values[order[k]]);

         // page window slightly larger than the table, so hits and evictions mix
         space = 20'hFFFFF / cur_page_bytes() + 1;
         span = table_capacity + $urandom_range(0, table_capacity / 2 + 2);
         if (span > space) span = space;
         base = (space > span) ? $urandom_range(0, space - span) : 0;
         burst = ($urandom_range(0, 3) == 0);

         for (n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(0, 49) == 0)
               write_register(CSR_UNMAPPED, PAGE_W'($urandom_range(0, 17'h1FFFF)));
            offer_translation(pick_address(base, span), burst ? 0 : pick_gap(),
                              1'b0, NO_XLAT);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Translated %0d addresses: %0d hits, %0d evictions, %0d free-slot fills,",
               translations_checked, hit_count, evict_count, fill_count);
      $display("over %0d register writes in %0d settings, with a %0d-cycle response hold-off.",
               register_writes, TOTAL_PHASES + 1, HOLD_OFF_CYCLES);
      if (translation_errors == 0)
         $display("page_table_lru_fifo_mapper regression: pass");
      else
         $display("page_table_lru_fifo_mapper regression: fail");
      $finish;
   end

endmodule
